// File: sv/ebb_pkg.sv
// ----------------------------------------------------------------------------
// ebb_pkg
// Shared types and constants of the embedding-bag backward block.
// ----------------------------------------------------------------------------
`default_nettype none

package ebb_pkg;

   localparam int VOCAB_ROWS_DEF = 1024;
   localparam int ROW_DIM_DEF    = 64;
   localparam int MAX_SEQ_DEF    = 64;

   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 7;

   localparam logic [CSR_IDX_W-1:0] CSR_MEAN_MODE = 1'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SEQ_LEN   = 1'd1;

   localparam logic KIND_WEIGHT_GRAD = 1'b0;
   localparam logic KIND_TABLE_GRAD  = 1'b1;

   typedef enum logic [1:0] {
      REQ_LOAD_TABLE = 2'd0,
      REQ_LOAD_GRAD  = 2'd1,
      REQ_BAG_POS    = 2'd2,
      REQ_READ_GRAD  = 2'd3
   } req_kind_type;

   typedef struct packed {
      req_kind_type       req_type;
      logic [9:0]         row_id;
      logic [5:0]         col;
      logic signed [15:0] elem_value;
      logic signed [15:0] sample_weight;
   } req_item_type;

   typedef struct packed {
      logic               result_kind;
      logic signed [47:0] result_value;
      logic               saturated;
   } rsp_item_type;

endpackage

`default_nettype wire

// File: sv/embedding_bag_backward.sv
// ----------------------------------------------------------------------------
// embedding_bag_backward
// Embedding-bag backward pass in signed Q8.8 with 48-bit gradient accumulators.
// ----------------------------------------------------------------------------
// Usage:
//   A transaction is taken at a clock edge with start high and busy low.
//   Load-table and load-gradient transactions are written in that cycle;
//   busy stays low.
//   A bag position walks the row, one column a cycle through a three-stage
//   read-multiply-write pipeline on the accumulator memory; in mean mode the
//   result also passes through a bit-serial divider.
//   A gradient readback reads one accumulator entry, divided in mean mode.
//   One transaction is worked at a time; busy stays high until the cycle
//   after the result strobe.
//   Each result is on rsp_data for exactly one cycle with rsp_valid high;
//   the receiver cannot stall it.
//   After reset the accumulator memory is cleared one entry a cycle while
//   busy is high. Register writes on the csr port are taken at any time
//   but belong in idle periods.
// ----------------------------------------------------------------------------
`default_nettype none

module embedding_bag_backward #(
   parameter int VOCAB_ROWS = ebb_pkg::VOCAB_ROWS_DEF,
   parameter int ROW_DIM    = ebb_pkg::ROW_DIM_DEF,
   parameter int MAX_SEQ    = ebb_pkg::MAX_SEQ_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   output logic                           busy,
   input  ebb_pkg::req_item_type          req_data,
   output logic                           rsp_valid,
   output ebb_pkg::rsp_item_type          rsp_data,
   input  logic                           csr_we,
   input  logic [ebb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [ebb_pkg::CSR_DATA_W-1:0] csr_wdata
);
   import ebb_pkg::*;

   localparam int DEPTH  = VOCAB_ROWS * ROW_DIM;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int COL_W  = (ROW_DIM > 1) ? $clog2(ROW_DIM) : 1;
   localparam int DIV_STEPS = 48;

   typedef enum logic [2:0] {
      ST_CLEAR, ST_IDLE, ST_SCAN, ST_DRAIN, ST_READ, ST_DIV, ST_OUT
   } state_type;

   // memories
   logic signed [15:0] table_mem [DEPTH];
   logic signed [47:0] accum_mem [DEPTH];
   logic signed [15:0] bag_mem   [ROW_DIM];

   state_type          state_ff, state_in;
   logic [ADDR_W-1:0]  clr_addr_ff, clr_addr_in;
   logic               mean_ff, mean_in;
   logic [6:0]         seq_len_ff, seq_len_in;
   logic               s1_vld_ff, s1_vld_in;
   logic               s2_vld_ff, s2_vld_in;

   logic [ADDR_W-1:0]  base_ff, base_in;
   logic [COL_W-1:0]   col_ff, col_in;
   logic signed [15:0] wt_ff, wt_in;
   logic [ADDR_W-1:0]  s1_addr_ff, s1_addr_in;
   logic [ADDR_W-1:0]  s2_addr_ff, s2_addr_in;
   logic signed [47:0] s2_acc_ff, s2_acc_in;
   logic signed [31:0] s2_pg_ff, s2_pg_in;
   logic signed [31:0] s2_pd_ff, s2_pd_in;
   logic signed [47:0] dot_ff, dot_in;
   logic [47:0]        num_ff, num_in;
   logic [6:0]         rem_ff, rem_in;
   logic [6:0]         div_ff, div_in;
   logic               neg_ff, neg_in;
   logic [5:0]         cnt_ff, cnt_in;
   logic signed [47:0] res_ff, res_in;
   logic               kind_ff, kind_in;

   logic signed [15:0] tbl_rd_ff;
   logic signed [47:0] acc_rd_ff;
   logic signed [15:0] bag_rd_ff;

   logic               accept;
   logic               row_ok;
   logic               col_ok;
   logic [ADDR_W-1:0]  req_addr;
   logic [ADDR_W-1:0]  scan_addr;
   logic [ADDR_W-1:0]  acc_raddr;
   logic signed [48:0] acc_sum;
   logic signed [47:0] acc_new;
   logic [6:0]         divisor;
   logic [7:0]         trial;
   logic               dot_to_div;
   logic signed [47:0] div_src;

   assign accept    = start && (state_ff == ST_IDLE);
   assign row_ok    = 32'(req_data.row_id) < VOCAB_ROWS;
   assign col_ok    = 32'(req_data.col) < ROW_DIM;
   assign req_addr  = ADDR_W'(ADDR_W'(req_data.row_id) * ADDR_W'(ROW_DIM))
                    + ADDR_W'(req_data.col);
   assign scan_addr = base_ff + ADDR_W'(col_ff);
   assign acc_raddr = (state_ff == ST_IDLE) ? req_addr : scan_addr;

   // accumulator update clips to 48 bits
   assign acc_sum = {s2_acc_ff[47], s2_acc_ff} + 49'(s2_pg_ff);
   always_comb begin
      if (acc_sum[48] != acc_sum[47]) begin
         acc_new = acc_sum[48] ? {1'b1, {47{1'b0}}} : {1'b0, {47{1'b1}}};
      end else begin
         acc_new = acc_sum[47:0];
      end
   end

   always_comb begin
      if (seq_len_ff == 7'd0) begin
         divisor = 7'd1;
      end else if (32'(seq_len_ff) > MAX_SEQ) begin
         divisor = 7'(MAX_SEQ);
      end else begin
         divisor = seq_len_ff;
      end
   end

   assign trial      = {rem_ff, num_ff[47]};
   assign dot_to_div = (state_ff == ST_DRAIN);
   assign div_src    = dot_to_div ? dot_ff : acc_rd_ff;

   always_comb begin
      state_in    = state_ff;
      clr_addr_in = clr_addr_ff;
      mean_in     = mean_ff;
      seq_len_in  = seq_len_ff;
      s1_vld_in   = 1'b0;
      s2_vld_in   = s1_vld_ff;
      base_in     = base_ff;
      col_in      = col_ff;
      wt_in       = wt_ff;
      s1_addr_in  = scan_addr;
      s2_addr_in  = s1_addr_ff;
      s2_acc_in   = acc_rd_ff;
      s2_pg_in    = bag_rd_ff * wt_ff;
      s2_pd_in    = tbl_rd_ff * bag_rd_ff;
      dot_in      = dot_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      div_in      = div_ff;
      neg_in      = neg_ff;
      cnt_in      = cnt_ff;
      res_in      = res_ff;
      kind_in     = kind_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_MEAN_MODE: mean_in    = csr_wdata[0];
            CSR_SEQ_LEN:   seq_len_in = csr_wdata;
            default: ;
         endcase
      end

      if (s2_vld_ff) begin
         dot_in = dot_ff + 48'(s2_pd_ff);
      end

      unique case (state_ff)
         ST_CLEAR: begin
            clr_addr_in = clr_addr_ff + 1'b1;
            if (32'(clr_addr_ff) == DEPTH - 1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               base_in = ADDR_W'(ADDR_W'(req_data.row_id) * ADDR_W'(ROW_DIM));
               wt_in   = req_data.sample_weight;
               col_in  = '0;
               dot_in  = '0;
               unique case (req_data.req_type)
                  REQ_BAG_POS: begin
                     kind_in = KIND_WEIGHT_GRAD;
                     if (row_ok) state_in = ST_SCAN;
                  end
                  REQ_READ_GRAD: begin
                     kind_in = KIND_TABLE_GRAD;
                     if (row_ok && col_ok) state_in = ST_READ;
                  end
                  default: ;
               endcase
            end
         end
         ST_SCAN: begin
            s1_vld_in = 1'b1;
            if (32'(col_ff) == ROW_DIM - 1) begin
               state_in = ST_DRAIN;
            end else begin
               col_in = col_ff + 1'b1;
            end
         end
         ST_DRAIN, ST_READ: begin
            if (state_ff == ST_READ || (!s1_vld_ff && !s2_vld_ff)) begin
               if (mean_ff) begin
                  neg_in   = div_src[47];
                  num_in   = div_src[47] ? 48'(-div_src) : 48'(div_src);
                  rem_in   = '0;
                  div_in   = divisor;
                  cnt_in   = '0;
                  state_in = ST_DIV;
               end else begin
                  res_in   = div_src;
                  state_in = ST_OUT;
               end
            end
         end
         ST_DIV: begin
            // restoring division, one quotient bit a cycle
            if (trial >= {1'b0, div_ff}) begin
               rem_in = 7'(trial - {1'b0, div_ff});
               num_in = {num_ff[46:0], 1'b1};
            end else begin
               rem_in = trial[6:0];
               num_in = {num_ff[46:0], 1'b0};
            end
            cnt_in = cnt_ff + 1'b1;
            if (32'(cnt_ff) == DIV_STEPS - 1) begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase

      if (state_ff == ST_DIV && state_in == ST_OUT) begin
         res_in = neg_ff ? -$signed(num_in) : $signed(num_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_CLEAR;
         clr_addr_ff <= '0;
         mean_ff     <= 1'b0;
         seq_len_ff  <= 7'd1;
         s1_vld_ff   <= 1'b0;
         s2_vld_ff   <= 1'b0;
         res_ff      <= '0;
         kind_ff     <= KIND_WEIGHT_GRAD;
      end else begin
         state_ff    <= state_in;
         clr_addr_ff <= clr_addr_in;
         mean_ff     <= mean_in;
         seq_len_ff  <= seq_len_in;
         s1_vld_ff   <= s1_vld_in;
         s2_vld_ff   <= s2_vld_in;
         res_ff      <= res_in;
         kind_ff     <= kind_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff    <= base_in;
      col_ff     <= col_in;
      wt_ff      <= wt_in;
      s1_addr_ff <= s1_addr_in;
      s2_addr_ff <= s2_addr_in;
      s2_acc_ff  <= s2_acc_in;
      s2_pg_ff   <= s2_pg_in;
      s2_pd_ff   <= s2_pd_in;
      dot_ff     <= dot_in;
      num_ff     <= num_in;
      rem_ff     <= rem_in;
      div_ff     <= div_in;
      neg_ff     <= neg_in;
      cnt_ff     <= cnt_in;
   end

   // memory ports
   always_ff @(posedge clock) begin
      tbl_rd_ff <= table_mem[scan_addr];
      acc_rd_ff <= accum_mem[acc_raddr];
      bag_rd_ff <= bag_mem[col_ff];
      if (accept && req_data.req_type == REQ_LOAD_TABLE && row_ok && col_ok) begin
         table_mem[req_addr] <= req_data.elem_value;
      end
      if (accept && req_data.req_type == REQ_LOAD_GRAD && col_ok) begin
         bag_mem[COL_W'(req_data.col)] <= req_data.elem_value;
      end
      if (state_ff == ST_CLEAR) begin
         accum_mem[clr_addr_ff] <= '0;
      end else if (s2_vld_ff) begin
         accum_mem[s2_addr_ff] <= acc_new;
      end
   end

   assign busy                  = (state_ff != ST_IDLE);
   assign rsp_valid             = (state_ff == ST_OUT);
   assign rsp_data.result_kind  = kind_ff;
   assign rsp_data.result_value = res_ff;
   // dot magnitude stays at most 2^36 with the default ROW_DIM of 64, so no clip occurs
   assign rsp_data.saturated    = 1'b0;

endmodule

`default_nettype wire

// File: sv/ebb_checker.sv
// ----------------------------------------------------------------------------
// ebb_checker
// Port-level checks of the embedding-bag backward block.
// ----------------------------------------------------------------------------
`default_nettype none

module ebb_checker (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  start,
   input wire logic                  busy,
   input wire ebb_pkg::req_item_type req_data,
   input wire logic                  rsp_valid,
   input wire ebb_pkg::rsp_item_type rsp_data
);
   import ebb_pkg::*;

   // a result only appears while a transaction is in flight
   a_rsp_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy) else $error("result outside a transaction");

   // one result per transaction, block returns to idle after it
   a_rsp_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid && !busy) else $error("repeated result");

   // loads complete in the cycle they are taken
   a_load_fast: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && (req_data.req_type == REQ_LOAD_TABLE ||
       req_data.req_type == REQ_LOAD_GRAD)) |=> !busy && !rsp_valid)
      else $error("load held the block");

   // a readback never reports a clip
   a_read_nosat: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.result_kind == KIND_TABLE_GRAD) |-> !rsp_data.saturated)
      else $error("readback flagged saturated");

endmodule

bind embedding_bag_backward ebb_checker u_ebb_checker (.*);

`default_nettype wire

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for embedding_bag_backward: table and gradient loads,
// bag positions and readbacks under sum and mean pooling, with a bit-exact
// predictor, random stimulus and random sender gaps.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;
   import ebb_pkg::*;

   localparam int  NROWS = VOCAB_ROWS_DEF;
   localparam int  NCOLS = ROW_DIM_DEF;
   localparam int  CYCLE_LIMIT = 2000000;
   localparam longint ACC_MAX = 64'sd140737488355327;
   localparam longint ACC_MIN = -64'sd140737488355328;

   typedef struct {
      req_item_type req;
      bit           typed;
      rsp_item_type want;
   } dir_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic start = 1'b0;
   logic busy;
   req_item_type req_data = '0;
   logic rsp_valid;
   rsp_item_type rsp_data;
   logic csr_we = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_wdata = '0;

   // predictor state
   shortint emb_table [NROWS*NCOLS];
   longint  grad_acc [NROWS*NCOLS];
   shortint bag_grad [NCOLS];
   bit      pool_mean;
   int      pool_len;

   rsp_item_type pending_rsp [$];
   dir_row_type  dir_tab [$];
   int           errors = 0;
   int           cycles = 0;
   bit           idle_on = 1'b1;
   int           pool_rows [4] = '{0, 1023, 341, 682};

   embedding_bag_backward dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_data(req_data), .rsp_valid(rsp_valid), .rsp_data(rsp_data),
      .csr_we(csr_we), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   initial begin
      forever #6 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t timeout", $time);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic longint clip48(longint v, output bit hit);
      hit = 1'b0;
      if (v > ACC_MAX) begin
         hit = 1'b1;
         return ACC_MAX;
      end
      if (v < ACC_MIN) begin
         hit = 1'b1;
         return ACC_MIN;
      end
      return v;
   endfunction

   function automatic longint pool_div(longint v);
      longint d;
      if (!pool_mean) return v;
      d = pool_len;
      if (d == 0) d = 1;
      if (d > MAX_SEQ_DEF) d = MAX_SEQ_DEF;
      return v / d;
   endfunction

   // updates predictor state; returns 1 when the transaction yields a result
   function automatic bit bag_grad_step(req_item_type it, output rsp_item_type r);
      int     base;
      longint dot;
      longint s;
      longint v;
      bit     hit;
      bit     dummy;
      base = int'(it.row_id) * NCOLS;
      r = '0;
      case (it.req_type)
         REQ_LOAD_TABLE: begin
            emb_table[base + it.col] = it.elem_value;
            return 1'b0;
         end
         REQ_LOAD_GRAD: begin
            bag_grad[it.col] = it.elem_value;
            return 1'b0;
         end
         REQ_BAG_POS: begin
            dot = 0;
            for (int c = 0; c < NCOLS; c++) begin
               s = grad_acc[base + c] + longint'(bag_grad[c]) * longint'(it.sample_weight);
               grad_acc[base + c] = clip48(s, dummy);
               dot += longint'(emb_table[base + c]) * longint'(bag_grad[c]);
            end
            v = clip48(pool_div(dot), hit);
            r.result_kind = KIND_WEIGHT_GRAD;
            r.result_value = v[47:0];
            r.saturated = hit;
            return 1'b1;
         end
         default: begin
            v = pool_div(grad_acc[base + it.col]);
            r.result_kind = KIND_TABLE_GRAD;
            r.result_value = v[47:0];
            r.saturated = 1'b0;
            return 1'b1;
         end
      endcase
   endfunction

   // result checker
   always @(posedge clock) begin
      rsp_item_type w;
      if (!reset && rsp_valid) begin
         if (pending_rsp.size() == 0) begin
            $display("%0t unexpected result: exp none act %h", $time, rsp_data);
            errors++;
         end else begin
            w = pending_rsp.pop_front();
            if (w.result_kind !== rsp_data.result_kind) begin
               $display("%0t result_kind: exp %0d act %0d", $time, w.result_kind,
                        rsp_data.result_kind);
               errors++;
            end
            if (w.result_value !== rsp_data.result_value) begin
               $display("%0t result_value: exp %0d act %0d", $time, w.result_value,
                        rsp_data.result_value);
               errors++;
            end
            if (w.saturated !== rsp_data.saturated) begin
               $display("%0t saturated: exp %0d act %0d", $time, w.saturated,
                        rsp_data.saturated);
               errors++;
            end
         end
      end
   end

   task automatic issue(req_item_type it, bit typed, rsp_item_type want);
      rsp_item_type r;
      if (idle_on && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      start <= 1'b1;
      req_data <= it;
      do @(posedge clock); while (busy);
      if (bag_grad_step(it, r)) pending_rsp.insert(pending_rsp.size(), typed ? want : r);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      do @(posedge clock); while (busy);
      repeat (4) @(posedge clock);
   endtask

   // leaves csr_we high; the caller lowers it after the last write
   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, int val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[CSR_DATA_W-1:0];
      @(posedge clock);
   endtask

   task automatic set_pooling(bit m, int len);
      drain();
      csr_write(CSR_MEAN_MODE, m);
      csr_write(CSR_SEQ_LEN, len);
      csr_we <= 1'b0;
      pool_mean = m;
      pool_len = len;
   endtask

   function automatic req_item_type mk(req_kind_type k, int row, int col, int e, int w);
      req_item_type it;
      it.req_type = k;
      it.row_id = row[9:0];
      it.col = col[5:0];
      it.elem_value = e[15:0];
      it.sample_weight = w[15:0];
      return it;
   endfunction

   function automatic void add_row(req_item_type it, bit typed, longint v, bit kind);
      dir_row_type d;
      d.req = it;
      d.typed = typed;
      d.want.result_kind = kind;
      d.want.result_value = v[47:0];
      d.want.saturated = 1'b0;
      dir_tab.insert(dir_tab.size(), d);
   endfunction

   initial begin
      rsp_item_type none;
      req_item_type it;
      int phase_m [7];
      int phase_l [7];
      int sel;
      int row;
      phase_m = '{0, 1, 1, 1, 1, 0, 1};
      phase_l = '{1, 1, 64, 127, 0, 64, 37};
      none = '0;
      foreach (emb_table[i]) emb_table[i] = 0;
      foreach (grad_acc[i]) grad_acc[i] = 0;
      foreach (bag_grad[i]) bag_grad[i] = 0;
      pool_mean = 1'b0;
      pool_len = 1;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      // wait out the accumulator clearing pass
      do @(posedge clock); while (busy);

      // accumulators read back zero after reset
      add_row(mk(REQ_READ_GRAD, 0, 0, 0, 0), 1'b1, 0, KIND_TABLE_GRAD);
      add_row(mk(REQ_READ_GRAD, 1023, 63, -1, -1), 1'b1, 0, KIND_TABLE_GRAD);
      add_row(mk(REQ_READ_GRAD, 682, 21, 0, 0), 1'b1, 0, KIND_TABLE_GRAD);
      foreach (dir_tab[i]) issue(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);
      dir_tab.delete();

      // load the gradient row and the table rows used by bag positions
      for (int c = 0; c < NCOLS; c++)
         issue(mk(REQ_LOAD_GRAD, $urandom_range(0, 1023), c,
                  c == 0 ? -32768 : c == 63 ? 32767 : $urandom_range(0, 65535), 0),
               1'b0, none);
      foreach (pool_rows[p])
         for (int c = 0; c < NCOLS; c++)
            issue(mk(REQ_LOAD_TABLE, pool_rows[p], c,
                     (c & 1) ? 32767 : ((c & 2) ? -32768 : $urandom_range(0, 65535)), 0),
                  1'b0, none);

      set_pooling(phase_m[0], phase_l[0]);

      // directed corners
      add_row(mk(REQ_BAG_POS, 0, 0, 0, 32767), 1'b0, 0, 0);
      add_row(mk(REQ_BAG_POS, 1023, 63, 0, -32768), 1'b0, 0, 0);
      add_row(mk(REQ_BAG_POS, 341, 5, 0, 0), 1'b0, 0, 0);
      add_row(mk(REQ_READ_GRAD, 0, 0, 0, 0), 1'b0, 0, 0);
      add_row(mk(REQ_READ_GRAD, 1023, 63, 0, 0), 1'b0, 0, 0);
      add_row(mk(REQ_LOAD_GRAD, 0, 0, 32767, 0), 1'b0, 0, 0);
      add_row(mk(REQ_LOAD_GRAD, 0, 63, -32768, 0), 1'b0, 0, 0);
      add_row(mk(REQ_LOAD_TABLE, 0, 5, -32768, 0), 1'b0, 0, 0);
      add_row(mk(REQ_BAG_POS, 0, 0, 0, -32768), 1'b0, 0, 0);
      add_row(mk(REQ_BAG_POS, 682, 0, 0, 1), 1'b0, 0, 0);
      add_row(mk(REQ_READ_GRAD, 0, 63, 0, 0), 1'b0, 0, 0);
      add_row(mk(REQ_READ_GRAD, 682, 63, 0, 0), 1'b0, 0, 0);
      add_row(mk(REQ_READ_GRAD, 341, 0, 0, 0), 1'b0, 0, 0);
      foreach (dir_tab[i]) issue(dir_tab[i].req, dir_tab[i].typed, dir_tab[i].want);

      for (int ph = 0; ph < 7; ph++) begin
         if (ph > 0) set_pooling(phase_m[ph], phase_l[ph]);
         if (ph == 6) idle_on = 1'b0;
         for (int n = 0; n < 70; n++) begin
            sel = $urandom_range(0, 99);
            row = pool_rows[$urandom_range(0, 3)];
            if (sel < 15)
               it = mk(REQ_LOAD_TABLE, $urandom_range(0, 1) ? row : $urandom_range(0, 1023),
                       $urandom_range(0, 63), $urandom_range(0, 65535), $urandom_range(0, 65535));
            else if (sel < 30)
               it = mk(REQ_LOAD_GRAD, $urandom_range(0, 1023), $urandom_range(0, 63),
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
            else if (sel < 70)
               it = mk(REQ_BAG_POS, row, $urandom_range(0, 63),
                       $urandom_range(0, 65535), $urandom_range(0, 65535));
            else
               it = mk(REQ_READ_GRAD, $urandom_range(0, 1) ? row : $urandom_range(0, 1023),
                       $urandom_range(0, 63), $urandom_range(0, 65535),
                       $urandom_range(0, 65535));
            issue(it, 1'b0, none);
         end
      end

      start <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (errors == 0 && pending_rsp.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: embedding_bag_backward.f
sv/ebb_pkg.sv
sv/embedding_bag_backward.sv
sv/ebb_checker.sv
bench/tb_top.sv
